// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files of the palette search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, disabled while reset is low.
`define NPCS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check whose consequent is taken in the cycle after its antecedent.
`define NPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `NPCS_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== hdl/npcs_pkg.sv =====
// Types and constants shared by the nearest palette color search modules.
package npcs_pkg;

  localparam int unsigned NUM_CH = 3;
  localparam int unsigned DIST_W = 18;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [7:0] CH_KEEP_MASK = 8'hFC;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_NEAREST = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] entry_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] nearest_index;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       palette_empty;
  } out_item_t;

  // Data handed from one distance cell to the next.
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [23:0]       entry;
    logic [DIST_W-1:0] dist_sum;
  } cell_bus_t;

  localparam out_item_t EMPTY_RESULT = '{
    nearest_index: 8'h00,
    red_out:       8'h00,
    green_out:     8'h00,
    blue_out:      8'h00,
    palette_empty: 1'b1
  };

endpackage

// ===== hdl/npcs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module npcs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/npcs_cell.sv =====
// One distance cell: adds the squared difference of one color channel and passes on.
module npcs_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [7:0]           query_i,
  input  npcs_pkg::cell_bus_t  bus_i,
  output npcs_pkg::cell_bus_t  bus_o
);

  logic [7:0]          query_q;
  logic [7:0]          chan;
  logic [7:0]          diff;
  logic [15:0]         sq;
  npcs_pkg::cell_bus_t bus_d;
  npcs_pkg::cell_bus_t bus_q;

  // The channel under work always sits in the top byte; the entry is shifted
  // so the neighbor finds its own channel there.
  always_comb begin
    chan = bus_i.entry[23:16];
    diff = (chan > query_q) ? (chan - query_q) : (query_q - chan);
    sq   = {8'h00, diff} * {8'h00, diff};
    bus_d.valid    = bus_i.valid;
    bus_d.last     = bus_i.last;
    bus_d.entry    = {bus_i.entry[15:0], 8'h00};
    bus_d.dist_sum = bus_i.dist_sum + npcs_pkg::DIST_W'(sq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q   <= '0;
      query_q <= '0;
    end else begin
      bus_q <= bus_d;
      if (load_i) begin
        query_q <= query_i;
      end
    end
  end

  assign bus_o = bus_q;

endmodule

// ===== hdl/nearest_palette_color_search.sv =====
// Top level of the nearest palette color search block.
// The block holds a palette of RGB entries in an on-chip RAM and answers
// queries against it. Items arrive on the in channel (valid/ready); a write
// item stores one entry and gives no result, a nearest query returns the index
// of the closest entry in use, and a read query returns the color of an entry.
// Results leave on the out channel (valid/ready) through an output register.
// The count of entries in use is set through the cfg channel, which is always
// ready; it must be written only while the block is idle. The block itself
// does not enforce this. A read query passes through the read state and the
// finish state on its way to the output register. A nearest query streams the
// palette out of the RAM read port, one entry per cycle, through a chain of
// three distance cells (one per channel); the single RAM read port sets the
// length of the scan. Queries on an empty palette skip the RAM and finish
// with the empty result. The block takes one item at a time. A finished result
// waits in a staging register while the receiver stalls; the next item is
// accepted once the result has moved to the output register.
// Reset clears the count and all control state. The palette contents are
// undefined until written.
`include "assert_macros.svh"

module nearest_palette_color_search #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  npcs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output npcs_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [8:0]          cfg_data_i
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned NW = (AW + 1 > 9) ? AW + 1 : 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_READ,
    ST_PICK,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [8:0]          color_count_q;
  logic [AW-1:0]       scan_addr_q;
  logic [AW-1:0]       last_addr_q;
  logic                rd_vld_q;
  logic                rd_last_q;
  logic [AW-1:0]       cnt_q;
  logic [AW-1:0]       best_idx_q;
  logic [npcs_pkg::DIST_W-1:0] best_d_q;
  npcs_pkg::out_item_t res_q;
  npcs_pkg::out_item_t out_q;
  logic                out_valid_q;

  logic [NW-1:0]       idx_ext;
  logic [NW-1:0]       cnt_ext;
  logic [NW-1:0]       n_used;
  logic [NW-1:0]       n_last;
  logic [NW-1:0]       rd_sel;
  logic [NW-1:0]       best_idx_ext;
  logic                n_empty;
  logic                wr_ok;
  logic                in_fire;
  logic                out_free;
  logic                scan_last;
  logic                better;
  logic                cell_load;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [23:0]         ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [23:0]         ram_rdata;

  npcs_pkg::cell_bus_t chain [npcs_pkg::NUM_CH+1];
  logic [7:0]          qch   [npcs_pkg::NUM_CH];
  npcs_pkg::cell_bus_t tail;

  // The count in use never exceeds the palette depth.
  always_comb begin
    idx_ext      = NW'(in_data_i.entry_index);
    cnt_ext      = NW'(color_count_q);
    n_used       = (cnt_ext > NW'(PALETTE_DEPTH)) ? NW'(PALETTE_DEPTH) : cnt_ext;
    n_last       = n_used - 1'b1;
    n_empty      = (n_used == '0);
    rd_sel       = (idx_ext < n_used) ? idx_ext : n_last;
    wr_ok        = (idx_ext < NW'(PALETTE_DEPTH));
    best_idx_ext = NW'(best_idx_q);
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign scan_last   = (scan_addr_q == last_addr_q);
  assign cfg_ready_o = 1'b1;
  assign cell_load   = in_fire && (in_data_i.kind == npcs_pkg::KIND_NEAREST);

  // RAM ports: writes come straight from the input, reads either from the
  // scan counter or from a read query.
  always_comb begin
    ram_we    = in_fire && (in_data_i.kind == npcs_pkg::KIND_WRITE) && wr_ok;
    ram_waddr = idx_ext[AW-1:0];
    ram_wdata = {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
    if (state_q == ST_SCAN) begin
      ram_re    = 1'b1;
      ram_raddr = scan_addr_q;
    end else begin
      ram_re    = in_fire && (in_data_i.kind == npcs_pkg::KIND_READ) && !n_empty;
      ram_raddr = rd_sel[AW-1:0];
    end
  end

  npcs_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The query color is cut to six bits per channel and held in the cells.
  assign qch[0] = in_data_i.red_in   & npcs_pkg::CH_KEEP_MASK;
  assign qch[1] = in_data_i.green_in & npcs_pkg::CH_KEEP_MASK;
  assign qch[2] = in_data_i.blue_in  & npcs_pkg::CH_KEEP_MASK;

  assign chain[0] = '{valid: rd_vld_q, last: rd_last_q, entry: ram_rdata, dist_sum: '0};

  for (genvar g = 0; g < npcs_pkg::NUM_CH; g++) begin : g_cell
    npcs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (cell_load),
      .query_i (qch[g]),
      .bus_i   (chain[g]),
      .bus_o   (chain[g+1])
    );
  end

  assign tail = chain[npcs_pkg::NUM_CH];
  // Strict less-than keeps the lower index on a tie, since entries arrive in order.
  assign better = tail.valid && (tail.dist_sum < best_d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      color_count_q <= '0;
      scan_addr_q   <= '0;
      last_addr_q   <= '0;
      rd_vld_q      <= 1'b0;
      rd_last_q     <= 1'b0;
      cnt_q         <= '0;
      best_idx_q    <= '0;
      best_d_q      <= npcs_pkg::DIST_MAX;
      res_q         <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // Every scan cycle launches one RAM read into the cell chain.
      rd_vld_q  <= (state_q == ST_SCAN);
      rd_last_q <= (state_q == ST_SCAN) && scan_last;

      if (cfg_valid_i) begin
        color_count_q <= cfg_data_i;
      end

      // The output register fills from the finish state and empties on a transfer.
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // Running minimum over the entries leaving the last cell.
      if (tail.valid) begin
        cnt_q <= cnt_q + 1'b1;
        if (better) begin
          best_d_q   <= tail.dist_sum;
          best_idx_q <= cnt_q;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_data_i.kind)
              npcs_pkg::KIND_NEAREST: begin
                if (n_empty) begin
                  res_q   <= npcs_pkg::EMPTY_RESULT;
                  state_q <= ST_FINISH;
                end else begin
                  scan_addr_q <= '0;
                  last_addr_q <= n_last[AW-1:0];
                  cnt_q       <= '0;
                  best_idx_q  <= '0;
                  best_d_q    <= npcs_pkg::DIST_MAX;
                  state_q     <= ST_SCAN;
                end
              end
              npcs_pkg::KIND_READ: begin
                if (n_empty) begin
                  res_q   <= npcs_pkg::EMPTY_RESULT;
                  state_q <= ST_FINISH;
                end else begin
                  state_q <= ST_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state_q <= ST_DRAIN;
          end else begin
            scan_addr_q <= scan_addr_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (tail.valid && tail.last) begin
            state_q <= ST_PICK;
          end
        end
        ST_READ: begin
          res_q <= '{
            nearest_index: 8'h00,
            red_out:       ram_rdata[23:16],
            green_out:     ram_rdata[15:8],
            blue_out:      ram_rdata[7:0],
            palette_empty: 1'b0
          };
          state_q <= ST_FINISH;
        end
        ST_PICK: begin
          res_q <= '{
            nearest_index: best_idx_ext[7:0],
            red_out:       8'h00,
            green_out:     8'h00,
            blue_out:      8'h00,
            palette_empty: 1'b0
          };
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_q   <= res_q;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Entries only leave the cell chain while a nearest query is scanning or draining.
  `NPCS_ASSERT(a_tail_in_scan, clk_i, rst_ni,
    !tail.valid || (state_q == ST_SCAN) || (state_q == ST_DRAIN),
    "distance chain produced an entry outside a nearest query")

  // Every entry in use has passed the running minimum before the pick.
  `NPCS_ASSERT(a_all_counted, clk_i, rst_ni,
    (state_q != ST_PICK) || (cnt_q == AW'(last_addr_q + 1'b1)),
    "nearest query picked before all entries were compared")

  // A new result enters the output register only from the finish state.
  `NPCS_ASSERT_NEXT(a_out_from_finish, clk_i, rst_ni,
    (state_q != ST_FINISH) && !(out_valid_q && !out_ready_i),
    !out_valid_q,
    "result transfer loaded outside the finish state")

endmodule
